// ===== sv/elwas_pkg.sv =====
// Shared types, codes and frame table for the EL wire animation sequencer.
package elwas_pkg;

    localparam int unsigned IN_TDATA_W  = 56;
    localparam int unsigned OUT_TDATA_W = 16;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    // configuration register indices
    localparam logic [CFG_IDX_W-1:0] CFG_FFT_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FFT_LAST   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANIM_FIRST = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANIM_LAST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_IVL  = 3'd4;

    localparam logic [15:0] FRAME_IVL_RST = 16'd100;

    // menu codes (MENU_SPARE is folded onto MENU_OTHER)
    localparam logic [1:0] MENU_CLOSED = 2'd0;
    localparam logic [1:0] MENU_ON     = 2'd1;
    localparam logic [1:0] MENU_OTHER  = 2'd2;
    localparam logic [1:0] MENU_SPARE  = 2'd3;

    // start request codes (REQ_SPARE is ignored)
    localparam logic [1:0] REQ_NONE  = 2'd0;
    localparam logic [1:0] REQ_RIGHT = 2'd1;
    localparam logic [1:0] REQ_LEFT  = 2'd2;
    localparam logic [1:0] REQ_SPARE = 2'd3;

    // animation start steps
    localparam logic [5:0] STEP_STOP  = 6'd0;
    localparam logic [5:0] STEP_BOOT  = 6'd10;
    localparam logic [5:0] STEP_RIGHT = 6'd20;
    localparam logic [5:0] STEP_LEFT  = 6'd30;
    localparam logic [5:0] STEP_OFF   = 6'd40;

    typedef enum logic [1:0] {
        MODE_OFF = 2'd0,
        MODE_ANI = 2'd1,
        MODE_FFT = 2'd2
    } disp_mode_t;

    typedef struct packed {
        logic [7:0]  fft_first;
        logic [7:0]  fft_last;
        logic [7:0]  anim_first;
        logic [7:0]  anim_last;
        logic [15:0] frame_ivl;
    } elwas_cfg_t;

    typedef struct packed {
        logic        suppress;
        logic [1:0]  start_request;
        logic [7:0]  band_recent;
        logic [7:0]  bg_mode;
        logic [1:0]  menu_sel;
        logic [31:0] now_ms;
    } elwas_item_t;

    typedef struct packed {
        logic [1:0]  last_menu;
        logic [5:0]  anim_step;
        logic [7:0]  held_pattern;
        logic [31:0] last_frame_ms;
        disp_mode_t  cur_mode;
    } elwas_state_t;

    // steps that show a frame and count down
    function automatic logic step_emits(input logic [5:0] s);
        logic r;
        case (s) inside
            [6'd3:6'd10], [6'd15:6'd20], [6'd25:6'd30], [6'd35:6'd40]: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] frame_pat(input logic [5:0] s);
        logic [7:0] p;
        case (s)
            6'd3:    p = 8'hFF;
            6'd4:    p = 8'h7F;
            6'd5:    p = 8'h3F;
            6'd6:    p = 8'h3E;
            6'd7:    p = 8'h3C;
            6'd8:    p = 8'h38;
            6'd9:    p = 8'h30;
            6'd10:   p = 8'h20;
            6'd15:   p = 8'hDF;
            6'd16:   p = 8'hEF;
            6'd17:   p = 8'hF7;
            6'd18:   p = 8'hFB;
            6'd19:   p = 8'hFD;
            6'd20:   p = 8'hFE;
            6'd25:   p = 8'hFE;
            6'd26:   p = 8'hFD;
            6'd27:   p = 8'hFB;
            6'd28:   p = 8'hF7;
            6'd29:   p = 8'hEF;
            6'd30:   p = 8'hDF;
            6'd35:   p = 8'h20;
            6'd36:   p = 8'h30;
            6'd37:   p = 8'h38;
            6'd38:   p = 8'h3C;
            6'd39:   p = 8'h3E;
            6'd40:   p = 8'h3F;
            default: p = 8'h00;
        endcase
        return p;
    endfunction

endpackage

// ===== sv/el_wire_animation_sequencer_unit.sv =====
// Top level of the EL wire animation sequencer: stream ports, registers, config.
//
// Usage:
//   Each s_ transaction is one update call (time, menu state, background mode,
//   recent-peak flags, sweep request, suppress). Each update yields exactly one
//   m_ transaction carrying the eight EL channel drive bits and the display mode.
//   Configuration registers are written through cfg_wr_en / cfg_index / cfg_data
//   while the unit is idle; an index beyond the register list is ignored.
// Pipeline and throughput:
//   Two stages: an input register, then the update logic feeding the result
//   register. An accepted input transaction is held in the input register,
//   then its result in the result register; one update is taken per cycle
//   while the result stage is empty or m_tready is high.
// Reset (aresetn low, synchronous):
//   Both stages empty, menu off, animation stopped, pattern and frame time zero,
//   display mode off; mode ranges 0..0 and frame interval 100 ms.
// Stall:
//   While m_tready is low the result is held; the input stage still fills, and
//   s_tready drops only once both stages are occupied. No transaction is lost.
module el_wire_animation_sequencer_unit
    import elwas_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // config write port
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // now_ms[31:0], menu_sel[33:32], bg_mode[41:34],
    // band_recent[49:42], start_request[51:50], suppress[52], zero pad
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // pattern[7:0], display_mode[9:8], zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    elwas_cfg_t   cfg_reg;
    elwas_state_t state_reg;
    elwas_state_t state_next;
    elwas_item_t  item_reg;
    logic         item_vld_reg;
    logic [7:0]   pat_reg;
    logic [7:0]   pat_next;
    disp_mode_t   mode_reg;
    disp_mode_t   mode_next;
    logic         out_vld_reg;
    logic         out_adv;
    logic         do_step;

    // result stage can take a new value when empty or being drained
    assign out_adv  = !out_vld_reg || m_tready;
    assign do_step  = item_vld_reg && out_adv;
    assign s_tready = !item_vld_reg || out_adv;

    elwas_step u_step (
        .cfg     (cfg_reg),
        .item    (item_reg),
        .cur     (state_reg),
        .nxt     (state_next),
        .pattern (pat_next),
        .mode    (mode_next)
    );

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fft_first  <= 8'd0;
            cfg_reg.fft_last   <= 8'd0;
            cfg_reg.anim_first <= 8'd0;
            cfg_reg.anim_last  <= 8'd0;
            cfg_reg.frame_ivl  <= FRAME_IVL_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_FFT_FIRST:  cfg_reg.fft_first  <= cfg_data[7:0];
                CFG_FFT_LAST:   cfg_reg.fft_last   <= cfg_data[7:0];
                CFG_ANIM_FIRST: cfg_reg.anim_first <= cfg_data[7:0];
                CFG_ANIM_LAST:  cfg_reg.anim_last  <= cfg_data[7:0];
                CFG_FRAME_IVL:  cfg_reg.frame_ivl  <= cfg_data;
                default: ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_vld_reg <= 1'b0;
        end else if (s_tready) begin
            item_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg <= elwas_item_t'(s_tdata[52:0]);
        end
    end

    // sequencer state, updated once per consumed transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.last_menu     <= MENU_CLOSED;
            state_reg.anim_step     <= STEP_STOP;
            state_reg.held_pattern  <= 8'h00;
            state_reg.last_frame_ms <= 32'd0;
            state_reg.cur_mode      <= MODE_OFF;
        end else if (do_step) begin
            state_reg <= state_next;
        end
    end

    // result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_adv) begin
            out_vld_reg <= item_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_step) begin
            pat_reg  <= pat_next;
            mode_reg <= mode_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'd0, mode_reg, pat_reg};

endmodule

// ===== sv/elwas_step.sv =====
// Next-state and result logic for one sequencer update.
module elwas_step
    import elwas_pkg::*;
(
    input  elwas_cfg_t   cfg,
    input  elwas_item_t  item,
    input  elwas_state_t cur,
    output elwas_state_t nxt,
    output logic [7:0]   pattern,
    output disp_mode_t   mode
);

    logic [1:0]  menu;
    logic [5:0]  step_a;
    logic [5:0]  step_b;
    logic [5:0]  step_c;
    disp_mode_t  mode_a;
    disp_mode_t  mode_b;
    logic [7:0]  pat_a;
    logic [7:0]  pat_b;
    logic [31:0] elapsed;
    logic        due;
    logic        in_fft;
    logic        in_anim;

    assign menu    = (item.menu_sel == MENU_CLOSED || item.menu_sel == MENU_ON)
                     ? item.menu_sel : MENU_OTHER;
    assign in_fft  = (item.bg_mode >= cfg.fft_first)
                     && (item.bg_mode <= cfg.fft_last);
    assign in_anim = (item.bg_mode >= cfg.anim_first)
                     && (item.bg_mode <= cfg.anim_last);
    assign elapsed = item.now_ms - cur.last_frame_ms;
    assign due     = elapsed > {16'd0, cfg.frame_ivl};

    always_comb begin
        // request first, menu transition overrides
        step_a = cur.anim_step;
        if (item.start_request == REQ_RIGHT) begin
            step_a = STEP_RIGHT;
        end else if (item.start_request == REQ_LEFT) begin
            step_a = STEP_LEFT;
        end

        mode_a = cur.cur_mode;
        step_b = step_a;
        if (menu == MENU_CLOSED) begin
            mode_a = MODE_OFF;
            if (cur.last_menu != menu) step_b = STEP_OFF;
        end else if (menu == MENU_ON) begin
            mode_a = MODE_ANI;
            if (cur.last_menu != menu) step_b = STEP_BOOT;
        end

        mode_b = mode_a;
        if (menu != MENU_CLOSED) begin
            if (in_fft) begin
                mode_b = MODE_FFT;
            end else if (in_anim) begin
                mode_b = MODE_ANI;
            end
        end

        // steady pattern when stopped
        pat_a = cur.held_pattern;
        if (step_b == STEP_STOP) begin
            case (mode_b)
                MODE_OFF: pat_a = 8'h00;
                MODE_ANI: pat_a = 8'hFF;
                default:  pat_a = item.band_recent;
            endcase
        end

        pat_b  = pat_a;
        step_c = step_b;
        if (due) begin
            if (step_emits(step_b)) begin
                pat_b  = frame_pat(step_b);
                step_c = step_b - 6'd1;
            end else begin
                step_c = STEP_STOP;
            end
        end

        nxt.last_menu     = menu;
        nxt.anim_step     = step_c;
        nxt.held_pattern  = item.suppress ? 8'h00 : pat_b;
        nxt.last_frame_ms = due ? item.now_ms : cur.last_frame_ms;
        nxt.cur_mode      = mode_b;
    end

    assign pattern = nxt.held_pattern;
    assign mode    = mode_b;

endmodule

// ===== sim/el_wire_animation_sequencer_unit_checker.sv =====
// Checker for the EL wire sequencer: own model of the update logic, result scoreboard.
`timescale 1ns / 1ps

module el_wire_animation_sequencer_unit_checker
    import elwas_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    output int                     fail_count,
    output int                     pending
);

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] pattern;
    } el_frame_t;

    // mode ranges and frame interval as last written
    logic [7:0]  fft_lo, fft_hi, ani_lo, ani_hi;
    logic [15:0] frame_gap;

    // sequencer state
    logic [1:0]  prev_menu;
    logic [5:0]  step;
    logic [7:0]  lamp_bits;
    logic [31:0] frame_stamp;
    disp_mode_t  shown_mode;

    el_frame_t   expected_frames[$];

    // frame shown at a step; zero for steps outside the four runs
    function automatic logic [7:0] frame_bits(input logic [5:0] s);
        logic [5:0] b;
        logic [7:0] bits;
        b = 6'd0;
        bits = 8'h00;
        // shutdown replays the start of boot backwards
        if (s >= 6'd3 && s <= 6'd10) b = s;
        else if (s >= 6'd35 && s <= 6'd40) b = 6'd45 - s;
        if (b != 6'd0) begin
            case (b)
                6'd3:    bits = 8'hFF;
                6'd4:    bits = 8'h7F;
                6'd5:    bits = 8'h3F;
                6'd6:    bits = 8'h3E;
                6'd7:    bits = 8'h3C;
                6'd8:    bits = 8'h38;
                6'd9:    bits = 8'h30;
                default: bits = 8'h20;
            endcase
        end else if (s >= 6'd15 && s <= 6'd20) begin
            bits = ~(8'h01 << (6'd20 - s));
        end else if (s >= 6'd25 && s <= 6'd30) begin
            bits = ~(8'h01 << (s - 6'd25));
        end
        return bits;
    endfunction

    function automatic el_frame_t advance_sequencer(input elwas_item_t up);
        logic [1:0] menu;
        logic [7:0] bits;
        el_frame_t  r;
        menu = (up.menu_sel == MENU_SPARE) ? MENU_OTHER : up.menu_sel;

        // sweep request first, a menu edge overrides it
        if (up.start_request == REQ_RIGHT) step = STEP_RIGHT;
        else if (up.start_request == REQ_LEFT) step = STEP_LEFT;

        if (menu == MENU_CLOSED) begin
            shown_mode = MODE_OFF;
            if (prev_menu != menu) step = STEP_OFF;
        end else if (menu == MENU_ON) begin
            shown_mode = MODE_ANI;
            if (prev_menu != menu) step = STEP_BOOT;
        end

        if (menu != MENU_CLOSED) begin
            if (up.bg_mode >= fft_lo && up.bg_mode <= fft_hi)
                shown_mode = MODE_FFT;
            else if (up.bg_mode >= ani_lo && up.bg_mode <= ani_hi)
                shown_mode = MODE_ANI;
        end

        if (step == STEP_STOP) begin
            case (shown_mode)
                MODE_OFF: lamp_bits = 8'h00;
                MODE_ANI: lamp_bits = 8'hFF;
                default:  lamp_bits = up.band_recent;
            endcase
        end

        // frame due: wrapped elapsed time strictly above the interval
        if ((up.now_ms - frame_stamp) > {16'd0, frame_gap}) begin
            bits = frame_bits(step);
            if (bits != 8'h00) begin
                lamp_bits = bits;
                step = step - 6'd1;
            end else begin
                step = STEP_STOP;
            end
            frame_stamp = up.now_ms;
        end

        if (up.suppress) lamp_bits = 8'h00;
        prev_menu = menu;

        r.mode = shown_mode;
        r.pattern = lamp_bits;
        return r;
    endfunction

    always @(posedge aclk) begin
        el_frame_t want;
        if (!aresetn) begin
            fft_lo = 8'd0;
            fft_hi = 8'd0;
            ani_lo = 8'd0;
            ani_hi = 8'd0;
            frame_gap = FRAME_IVL_RST;
            prev_menu = MENU_CLOSED;
            step = STEP_STOP;
            lamp_bits = 8'h00;
            frame_stamp = 32'd0;
            shown_mode = MODE_OFF;
            expected_frames.delete();
            fail_count = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_FFT_FIRST:  fft_lo = cfg_data[7:0];
                    CFG_FFT_LAST:   fft_hi = cfg_data[7:0];
                    CFG_ANIM_FIRST: ani_lo = cfg_data[7:0];
                    CFG_ANIM_LAST:  ani_hi = cfg_data[7:0];
                    CFG_FRAME_IVL:  frame_gap = cfg_data[15:0];
                    default: ;
                endcase
            end

            // results first: nothing accepted at this edge can already be out
            if (m_tvalid && m_tready) begin
                if (expected_frames.size() == 0) begin
                    fail_count++;
                    $display("%0t: result with none expected: expected none, got %04h",
                             $time, m_tdata);
                end else begin
                    want = expected_frames.pop_front();
                    if (m_tdata[7:0] !== want.pattern) begin
                        fail_count++;
                        $display("%0t: pattern mismatch: expected %02h, got %02h",
                                 $time, want.pattern, m_tdata[7:0]);
                    end
                    if (m_tdata[9:8] !== want.mode) begin
                        fail_count++;
                        $display("%0t: display_mode mismatch: expected %0d, got %0d",
                                 $time, want.mode, m_tdata[9:8]);
                    end
                end
            end

            if (s_tvalid && s_tready)
                expected_frames.push_back(advance_sequencer(s_tdata[$bits(elwas_item_t)-1:0]));
        end
        pending = expected_frames.size();
    end

endmodule

// ===== sim/el_wire_animation_sequencer_unit_tb.sv =====
// Testbench top for the EL wire sequencer: clock, reset, stimulus, verdict.
`timescale 1ns / 1ps

module el_wire_animation_sequencer_unit_tb;
    import elwas_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 210;
    localparam int HOLD_CYCLES  = 80;
    localparam int SETTLE       = 4;     // two-stage pipe plus margin

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tready  = 1'b0;
    wire                    s_tready;
    wire                    m_tvalid;
    wire [OUT_TDATA_W-1:0]  m_tdata;

    int          fail_count;
    int          pending;
    int          cycles = 0;
    int          updates_sent = 0;
    int          hold_at = 32'h7fff_ffff;  // update count that starts the long sink stall
    bit          hold_done = 1'b0;
    bit          calm = 1'b0;              // no idling on either side
    elwas_cfg_t  cfg_now;
    logic [31:0] clock_ms = 32'd0;
    logic [1:0]  menu_now = MENU_CLOSED;

    el_wire_animation_sequencer_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    el_wire_animation_sequencer_unit_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #2;
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("el_wire_animation_sequencer_unit_tb: done, errors");
            $finish;
        end
    end

    // result sink: random back-pressure, one long hold-off so both stages fill
    initial begin : result_sink
        forever begin
            if (!hold_done && updates_sent >= hold_at) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 24);
                @(posedge aclk);
            end
        end
    end

    // one update transaction; returns at the edge that accepted it
    task automatic send_update(input logic [31:0] now, input logic [1:0] menu,
                               input logic [7:0] bg, input logic [7:0] bands,
                               input logic [1:0] req, input logic sup);
        elwas_item_t up;
        up.now_ms        = now;
        up.menu_sel      = menu;
        up.bg_mode       = bg;
        up.band_recent   = bands;
        up.start_request = req;
        up.suppress      = sup;
        while (!calm && $urandom_range(99) < 24) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - $bits(elwas_item_t)){1'b0}}, up};
        do @(posedge aclk); while (!s_tready);
        updates_sent++;
    endtask

    // stop offering, wait for every result, then let the pipe settle
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // all five registers, back to back, unit idle
    task automatic program_ranges(input logic [7:0] fl, input logic [7:0] fh,
                                  input logic [7:0] al, input logic [7:0] ah,
                                  input logic [15:0] ivl);
        cfg_now.fft_first  = fl;
        cfg_now.fft_last   = fh;
        cfg_now.anim_first = al;
        cfg_now.anim_last  = ah;
        cfg_now.frame_ivl  = ivl;
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_FFT_FIRST;
        cfg_data  <= {8'd0, fl};
        @(posedge aclk);
        cfg_index <= CFG_FFT_LAST;
        cfg_data  <= {8'd0, fh};
        @(posedge aclk);
        cfg_index <= CFG_ANIM_FIRST;
        cfg_data  <= {8'd0, al};
        @(posedge aclk);
        cfg_index <= CFG_ANIM_LAST;
        cfg_data  <= {8'd0, ah};
        @(posedge aclk);
        cfg_index <= CFG_FRAME_IVL;
        cfg_data  <= ivl;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin : stimulus
        int          ph;
        int          k;
        int          pick;
        int unsigned ivl;
        logic [31:0] dt;
        logic [7:0]  bg;
        logic [1:0]  req;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset ranges 0..0, interval 100
        send_update(32'd0,    MENU_CLOSED, 8'd0,   8'h00, REQ_NONE,  1'b0);
        send_update(32'd50,   MENU_ON,     8'd0,   8'hA5, REQ_NONE,  1'b0); // boot starts
        send_update(32'd151,  MENU_ON,     8'd0,   8'h5A, REQ_NONE,  1'b0); // first frame
        send_update(32'd251,  MENU_ON,     8'd255, 8'hFF, REQ_NONE,  1'b0); // elapsed == interval
        send_update(32'd252,  MENU_ON,     8'd255, 8'h00, REQ_NONE,  1'b0); // one past
        send_update(32'd400,  MENU_ON,     8'd17,  8'h3C, REQ_RIGHT, 1'b0);
        send_update(32'd501,  MENU_ON,     8'd17,  8'hC3, REQ_LEFT,  1'b0);
        send_update(32'd602,  MENU_ON,     8'd17,  8'h3C, REQ_SPARE, 1'b0); // unused code
        send_update(32'd703,  MENU_OTHER,  8'd0,   8'h81, REQ_NONE,  1'b0); // other, in fft range
        send_update(32'd804,  MENU_SPARE,  8'd200, 8'h42, REQ_NONE,  1'b0); // other, mode held
        send_update(32'd905,  MENU_CLOSED, 8'd0,   8'hFF, REQ_RIGHT, 1'b0); // shutdown beats sweep
        send_update(32'd1006, MENU_CLOSED, 8'd255, 8'h00, REQ_NONE,  1'b1); // suppress
        send_update(32'd1107, MENU_CLOSED, 8'd255, 8'h00, REQ_NONE,  1'b0);
        send_update(32'd1208, MENU_ON,     8'd0,   8'h00, REQ_LEFT,  1'b0); // boot beats sweep
        send_update(32'hFFFF_FF00, MENU_ON, 8'd128, 8'hFF, REQ_NONE, 1'b0); // big jump
        send_update(32'hFFFF_FFFF, MENU_ON, 8'd0,   8'h01, REQ_NONE, 1'b1);
        send_update(32'h0000_0010, MENU_ON, 8'd0,   8'h80, REQ_NONE, 1'b0); // wrapped, not due
        send_update(32'h0000_0080, MENU_OTHER, 8'd255, 8'h7F, REQ_NONE, 1'b0); // wrapped, due
        send_update(32'h0000_00E6, MENU_ON, 8'd0,   8'hFF, REQ_NONE, 1'b0);
        send_update(32'h0000_014C, MENU_ON, 8'd0,   8'hFF, REQ_NONE, 1'b0);
        send_update(32'h0000_01B2, MENU_SPARE, 8'd0,   8'hFF, REQ_SPARE, 1'b1);
        send_update(32'hFFFF_FFFF, MENU_SPARE, 8'd255, 8'hFF, REQ_SPARE, 1'b1); // all at top
        clock_ms = 32'hFFFF_FFFF;
        menu_now = MENU_SPARE;

        for (ph = 0; ph < PHASES; ph++) begin
            drain();
            case (ph)
                0: program_ranges(8'd10,  8'd20,  8'd30,  8'd40,  16'd100);
                1: program_ranges(8'd0,   8'd255, 8'd0,   8'd255, 16'd0);     // all spectrum
                2: program_ranges(8'd255, 8'd0,   8'd0,   8'd255, 16'd65535); // fft empty
                3: program_ranges(8'd128, 8'd255, 8'd0,   8'd127, 16'd1);
                4: program_ranges(8'd50,  8'd60,  8'd55,  8'd70,  16'd20);    // overlap
                5: program_ranges(8'd200, 8'd100, 8'd150, 8'd50,  16'd100);   // both empty
                default: program_ranges(8'($urandom_range(255)), 8'($urandom_range(255)),
                                        8'($urandom_range(255)), 8'($urandom_range(255)),
                                        16'($urandom_range(300)));
            endcase
            // phase 3 runs flat out, with the sink stall part way in
            calm = (ph == 3);
            if (ph == 3) hold_at = updates_sent + 40;
            ivl = 32'(cfg_now.frame_ivl);

            for (k = 0; k < PHASE_ITEMS; k++) begin
                // time base: mostly just past the interval so frames step
                pick = $urandom_range(99);
                if (pick < 45) dt = ivl + 1 + $urandom_range(2);
                else if (pick < 55) dt = ivl;
                else if (pick < 75) dt = $urandom_range(ivl);
                else if (pick < 90) dt = $urandom_range(3);
                else dt = $urandom;
                clock_ms = clock_ms + dt;

                // menu held for stretches so animations can run out
                if ($urandom_range(99) < 7) menu_now = 2'($urandom_range(3));

                pick = $urandom_range(99);
                if (pick < 5) req = REQ_RIGHT;
                else if (pick < 10) req = REQ_LEFT;
                else if (pick < 12) req = REQ_SPARE;
                else req = REQ_NONE;

                // background mode often on a range edge
                if ($urandom_range(99) < 35) begin
                    case ($urandom_range(7))
                        0: bg = cfg_now.fft_first;
                        1: bg = cfg_now.fft_last;
                        2: bg = cfg_now.anim_first;
                        3: bg = cfg_now.anim_last;
                        4: bg = cfg_now.fft_first - 8'd1;
                        5: bg = cfg_now.fft_last + 8'd1;
                        6: bg = cfg_now.anim_first - 8'd1;
                        default: bg = cfg_now.anim_last + 8'd1;
                    endcase
                end else begin
                    bg = 8'($urandom_range(255));
                end

                send_update(clock_ms, menu_now, bg, 8'($urandom_range(255)), req,
                            $urandom_range(99) < 5);
            end
        end

        drain();
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("el_wire_animation_sequencer_unit_tb: done, clean");
        end else begin
            $display("el_wire_animation_sequencer_unit_tb: done, errors");
        end
        $finish;
    end

endmodule
